// ----- design/lgm_pkg.sv -----
package lgm_pkg;

    typedef enum logic [1:0] {
        REQ_SCAN_START = 2'd0,
        REQ_SAMPLE     = 2'd1,
        REQ_SCAN_END   = 2'd2,
        REQ_CELL_READ  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_RIGHT   = 2'd1,
        MODE_LEFT    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_FOV_START = 3'd0,
        REG_ANGLE_STEP = 3'd1,
        REG_ARC_FIRST = 3'd2,
        REG_ARC_END = 3'd3,
        REG_OBST_THR = 3'd4,
        REG_MAX_RANGE = 3'd5,
        REG_STEP_DIST = 3'd6,
        REG_AVOID_TICKS = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CORDIC,
        BK_MUL,
        BK_ADD,
        BK_SCALE,
        BK_CLEAR
    } bk_state_t;

    localparam int CORDIC_STEPS = 14;
    localparam logic signed [17:0] CORDIC_START = 18'sd9949;
    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] NO_RETURN = 16'hFFFF;

    // Queue entry passed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  kind;     // 0 pose step, 1 map sample, 2 scan-end/report, 3 cell read
        logic [15:0] angle;
        logic [15:0] range;
        logic [1:0]  mode;
        logic        hit;
        logic [15:0] nearest;
        logic [9:0]  qx;
        logic [9:0]  qy;
    } job_t;

    localparam logic [1:0] JOB_POSE = 2'd0;
    localparam logic [1:0] JOB_MAP = 2'd1;
    localparam logic [1:0] JOB_REPORT = 2'd2;
    localparam logic [1:0] JOB_READ = 2'd3;

    function automatic logic signed [17:0] atan_val(input logic [3:0] i);
        unique case (i)
            4'd0: atan_val = 18'sd8192;
            4'd1: atan_val = 18'sd4836;
            4'd2: atan_val = 18'sd2555;
            4'd3: atan_val = 18'sd1297;
            4'd4: atan_val = 18'sd651;
            4'd5: atan_val = 18'sd326;
            4'd6: atan_val = 18'sd163;
            4'd7: atan_val = 18'sd81;
            4'd8: atan_val = 18'sd41;
            4'd9: atan_val = 18'sd20;
            4'd10: atan_val = 18'sd10;
            4'd11: atan_val = 18'sd5;
            4'd12: atan_val = 18'sd3;
            4'd13: atan_val = 18'sd1;
            default: atan_val = 18'sd0;
        endcase
    endfunction

endpackage

// ----- design/lgm_front.sv -----
module lgm_front
    import lgm_pkg::*;
#(
    parameter int MAX_RAYS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        valid,
    output logic        stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] range_value,
    input  logic [11:0] ray_index,
    input  logic [15:0] yaw,
    input  logic [6:0]  cell_x,
    input  logic [6:0]  cell_y,
    output logic        job_valid,
    output job_t        job,
    input  logic        job_take,
    input  logic        back_busy,
    output logic [15:0] step_distance
);

    logic [15:0] fov_reg, step_reg, thr_reg, maxr_reg, dist_reg;
    logic [11:0] arc_first_reg;
    logic [12:0] arc_end_reg;
    logic [7:0]  ticks_reg;
    logic [15:0] heading_reg;
    logic [7:0]  avoid_reg;
    logic        turn_right_reg, hit_reg;
    logic [15:0] nearest_reg, lfsr_reg;
    // Two-entry queue.
    job_t        q_reg [2];
    logic [1:0]  cnt_reg;
    logic        rd_reg, wr_reg;

    logic        accept, push;
    job_t        nj;
    logic [15:0] lfsr_n;
    logic [15:0] ray_ang;
    logic        in_arc, ray_ok;

    assign step_distance = dist_reg;
    assign stall = (cnt_reg == 2'd2) || back_busy;
    assign accept = valid && !stall;
    assign job_valid = cnt_reg != 2'd0;
    assign job = q_reg[rd_reg];

    assign lfsr_n = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    assign ray_ang = fov_reg + 16'(ray_index * step_reg) + heading_reg;
    assign in_arc = ({1'b0, ray_index} >= {1'b0, arc_first_reg}) &&
                    ({1'b0, ray_index} < arc_end_reg) && (range_value < thr_reg);
    assign ray_ok = 32'(ray_index) < 32'(MAX_RAYS);

    always_comb
    begin
        nj = '0;
        push = 1'b0;
        nj.range = range_value;
        nj.qx = 10'(cell_x);
        nj.qy = 10'(cell_y);
        unique case (req_type)
            REQ_SCAN_START:
            begin
                nj.kind = JOB_POSE;
                nj.angle = yaw;
                push = (avoid_reg == 8'd0);
            end
            REQ_SAMPLE:
            begin
                nj.kind = JOB_MAP;
                nj.angle = ray_ang;
                push = ray_ok && (range_value != NO_RETURN) && (range_value <= maxr_reg)
                       && !ray_index[0];
            end
            REQ_SCAN_END:
            begin
                nj.kind = JOB_REPORT;
                nj.hit = hit_reg;
                nj.nearest = nearest_reg;
                nj.mode = (avoid_reg != 8'd0) ? (turn_right_reg ? MODE_RIGHT : MODE_LEFT)
                                              : MODE_FORWARD;
                push = 1'b1;
            end
            default:
            begin
                nj.kind = JOB_READ;
                push = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && push)
            q_reg[wr_reg] <= nj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_reg <= 16'hC000;
            step_reg <= 16'd64;
            arc_first_reg <= 12'd179;
            arc_end_reg <= 13'd332;
            thr_reg <= 16'd614;
            maxr_reg <= 16'd5120;
            dist_reg <= 16'd51;
            ticks_reg <= 8'd20;
            heading_reg <= '0;
            avoid_reg <= '0;
            turn_right_reg <= 1'b1;
            hit_reg <= 1'b0;
            nearest_reg <= 16'd5120;
            lfsr_reg <= LFSR_SEED;
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_FOV_START: fov_reg <= cfg_data;
                    REG_ANGLE_STEP: step_reg <= cfg_data;
                    REG_ARC_FIRST: arc_first_reg <= cfg_data[11:0];
                    REG_ARC_END: arc_end_reg <= cfg_data[12:0];
                    REG_OBST_THR: thr_reg <= cfg_data;
                    REG_MAX_RANGE: maxr_reg <= cfg_data;
                    REG_STEP_DIST: dist_reg <= cfg_data;
                    default: ticks_reg <= cfg_data[7:0];
                endcase
            end
            if (accept)
            begin
                unique case (req_type)
                    REQ_SCAN_START:
                    begin
                        heading_reg <= yaw;
                        hit_reg <= 1'b0;
                        nearest_reg <= maxr_reg;
                    end
                    REQ_SAMPLE:
                    begin
                        if (ray_ok && in_arc)
                        begin
                            hit_reg <= 1'b1;
                            if (range_value < nearest_reg)
                                nearest_reg <= range_value;
                        end
                    end
                    REQ_SCAN_END:
                    begin
                        if (avoid_reg != 8'd0)
                            avoid_reg <= avoid_reg - 8'd1;
                        else if (hit_reg)
                        begin
                            avoid_reg <= ticks_reg;
                            lfsr_reg <= lfsr_n;
                            turn_right_reg <= lfsr_n[0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (accept && push)
                wr_reg <= ~wr_reg;
            if (job_take)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(accept && push) - 2'(job_take);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid) else $error("take from empty queue");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> stall) else $error("full queue not stalling");

endmodule

// ----- design/lgm_back.sv -----
module lgm_back
    import lgm_pkg::*;
#(
    parameter int GRID_SIDE = 128,
    parameter int CELLS_PER_METER = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    output logic        busy,
    input  logic [15:0] step_distance,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  drive_mode,
    output logic        obstacle_ahead,
    output logic [15:0] nearest_range,
    output logic        cell_occupied
);

    localparam int AW = $clog2(GRID_SIDE);
    localparam int CELLS = 1 << (2 * AW);
    localparam int HALF = GRID_SIDE / 2;

    logic mem [CELLS];

    bk_state_t   st_reg, st_next;
    job_t        j_reg;
    logic [3:0]  it_reg, it_next;
    logic signed [17:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic        flip_reg;
    logic signed [47:0] px_reg, py_reg, px_next, py_next;
    logic signed [34:0] mx_reg, my_reg;
    logic signed [47:0] gx_reg, gy_reg;
    logic signed [47:0] cx_reg, cy_reg;
    logic [2*AW-1:0] clr_reg;
    logic        rd_pend_reg;
    logic        ov_reg;
    logic [1:0]  om_reg;
    logic        oh_reg, oc_reg;
    logic [15:0] on_reg;

    logic signed [17:0] cs, sn, xs, ys;
    logic [15:0] a0;
    logic        out_free;
    logic signed [16:0] mul_d;
    logic signed [56:0] sx, sy;

    assign drive_mode = om_reg;
    assign obstacle_ahead = oh_reg;
    assign nearest_range = on_reg;
    assign cell_occupied = oc_reg;
    assign out_valid = ov_reg;
    assign out_free = !ov_reg || !out_stall;
    assign busy = st_reg != BK_IDLE;

    assign a0 = (job.angle >= 16'd16384 && job.angle < 16'd49152) ?
                job.angle - 16'd32768 : job.angle;
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign cs = flip_reg ? -x_reg : x_reg;
    assign sn = flip_reg ? -y_reg : y_reg;
    assign mul_d = (j_reg.kind == JOB_POSE) ? $signed({1'b0, step_distance})
                                            : $signed({1'b0, j_reg.range});
    // Scaling to cells truncates toward zero like a signed division.
    assign sx = 57'(gx_reg) * CELLS_PER_METER;
    assign sy = 57'(gy_reg) * CELLS_PER_METER;

    always_comb
    begin
        st_next = st_reg;
        it_next = it_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        px_next = px_reg;
        py_next = py_reg;
        job_take = 1'b0;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (job_valid && out_free && !rd_pend_reg)
                begin
                    job_take = 1'b1;
                    if (job.kind == JOB_POSE || job.kind == JOB_MAP)
                    begin
                        st_next = BK_CORDIC;
                        it_next = '0;
                        x_next = CORDIC_START;
                        y_next = '0;
                        z_next = 18'(signed'(a0));
                    end
                end
            end
            BK_CORDIC:
            begin
                if (!z_reg[17])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_val(it_reg);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_val(it_reg);
                end
                it_next = it_reg + 4'd1;
                if (it_reg == 4'(CORDIC_STEPS - 1))
                    st_next = BK_MUL;
            end
            BK_MUL:
                st_next = BK_ADD;
            BK_ADD:
            begin
                if (j_reg.kind == JOB_POSE)
                begin
                    px_next = 48'(32'(px_reg + 48'(mx_reg >>> 14)));
                    py_next = 48'(32'(py_reg + 48'(my_reg >>> 14)));
                    st_next = BK_IDLE;
                end
                else
                    st_next = BK_SCALE;
            end
            BK_SCALE:
                st_next = BK_CLEAR;
            default:
                st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && job_take)
        begin
            j_reg <= job;
            flip_reg <= (job.angle >= 16'd16384 && job.angle < 16'd49152);
        end
        if (st_reg == BK_MUL)
        begin
            mx_reg <= 35'(mul_d * cs);
            my_reg <= 35'(mul_d * sn);
        end
        if (st_reg == BK_ADD)
        begin
            gx_reg <= 48'(signed'(px_reg[31:0])) + 48'(mx_reg >>> 14);
            gy_reg <= 48'(signed'(py_reg[31:0])) + 48'(my_reg >>> 14);
        end
        if (st_reg == BK_SCALE)
        begin
            cx_reg <= 48'(HALF) + 48'(sx / 1024);
            cy_reg <= 48'(HALF) - 48'(sy / 1024);
        end
        if (rd_pend_reg)
            mem[clr_reg] <= 1'b0;
        else if (st_reg == BK_CLEAR && cx_reg >= 0 && cx_reg < GRID_SIDE &&
                 cy_reg >= 0 && cy_reg < GRID_SIDE)
            mem[{cy_reg[AW-1:0], cx_reg[AW-1:0]}] <= 1'b1;
        if (st_reg == BK_IDLE && job_take && job.kind == JOB_READ)
            oc_reg <= (job.qx < 10'(GRID_SIDE) && job.qy < 10'(GRID_SIDE)) ?
                      mem[{job.qy[AW-1:0], job.qx[AW-1:0]}] : 1'b0;
        else if (st_reg == BK_IDLE && job_take && job.kind == JOB_REPORT)
            oc_reg <= 1'b0;
        if (st_reg == BK_IDLE && job_take && job.kind == JOB_REPORT)
        begin
            om_reg <= job.mode;
            oh_reg <= job.hit;
            on_reg <= job.nearest;
        end
        else if (st_reg == BK_IDLE && job_take && job.kind == JOB_READ)
        begin
            om_reg <= MODE_FORWARD;
            oh_reg <= 1'b0;
            on_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_CLEAR;
            it_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            clr_reg <= '0;
            rd_pend_reg <= 1'b1;
            ov_reg <= 1'b0;
        end
        else
        begin
            it_reg <= it_next;
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            px_reg <= px_next;
            py_reg <= py_next;
            // After reset, sweep the grid to unknown before taking jobs.
            if (rd_pend_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == (2*AW)'(CELLS - 1))
                begin
                    rd_pend_reg <= 1'b0;
                    st_reg <= BK_IDLE;
                end
            end
            else
                st_reg <= st_next;
            if (out_free)
                ov_reg <= job_take && (job.kind == JOB_REPORT || job.kind == JOB_READ);
        end
    end

    a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_CORDIC && it_reg == 4'(CORDIC_STEPS - 1)) |=> st_reg == BK_MUL)
        else $error("cordic did not finish");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg && $stable(on_reg))
        else $error("stalled result changed");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> st_reg == BK_IDLE) else $error("take while busy");

endmodule

// ----- design/lidar_grid_mapper_avoider.sv -----
// Lidar occupancy-grid mapper with obstacle avoidance.
// Requests come in on valid/stall with req_type: scan start, range sample,
// scan end or cell read. Configuration is written by cfg_write with cfg_index and
// cfg_data; the user must do so only while the block is idle, which is unchecked.
// Scan ends and cell reads give one result on out_valid/out_stall; scan starts
// and samples give none.
// The front part classifies each request, keeps the scan flags and the
// avoidance state and pushes a job into a two-entry queue. The back part
// runs a 14-iteration CORDIC, a multiply, a pose add and a cell scaling.
// A mapped sample holds the back part through CORDIC, MUL, ADD, SCALE and CLEAR,
// a pose step through CORDIC, MUL and ADD; the input stalls while it is busy.
// A scan end or cell read is taken from the queue once the back part is idle
// and the output is free, and its result is registered as it is taken.
// Other samples are taken one per cycle while the back part is idle and the queue is not full.
// After reset the grid is cleared one cell a cycle, all 16384 cells of the
// default 128 x 128 grid, during which no request is accepted.
// A stalled result holds in the output register; the back part waits.
module lidar_grid_mapper_avoider
    import lgm_pkg::*;
#(
    parameter int GRID_SIDE = 128,
    parameter int CELLS_PER_METER = 10,
    parameter int MAX_RAYS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] range_value,
    input  logic [11:0] ray_index,
    input  logic signed [15:0] yaw,
    input  logic [6:0]  cell_x,
    input  logic [6:0]  cell_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  drive_mode,
    output logic        obstacle_ahead,
    output logic [15:0] nearest_range,
    output logic        cell_occupied
);

    logic        job_valid, job_take, back_busy;
    job_t        job;
    logic [15:0] step_distance;

    lgm_front #(.MAX_RAYS(MAX_RAYS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .valid(in_valid), .stall(in_stall),
        .req_type(req_type), .range_value(range_value), .ray_index(ray_index),
        .yaw(yaw), .cell_x(cell_x), .cell_y(cell_y),
        .job_valid(job_valid), .job(job), .job_take(job_take),
        .back_busy(back_busy),
        .step_distance(step_distance)
    );

    lgm_back #(.GRID_SIDE(GRID_SIDE), .CELLS_PER_METER(CELLS_PER_METER)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job(job), .job_take(job_take), .busy(back_busy),
        .step_distance(step_distance),
        .out_valid(out_valid), .out_stall(out_stall),
        .drive_mode(drive_mode), .obstacle_ahead(obstacle_ahead),
        .nearest_range(nearest_range), .cell_occupied(cell_occupied)
    );

endmodule
